// ----- hdl/pidc_pkg.sv -----
package pidc_pkg;

    // item operation codes
    typedef enum logic [2:0] {
        FUNC_UPDATE_DIFF = 3'd0,
        FUNC_UPDATE_RATE = 3'd1,
        FUNC_RESET       = 3'd2,
        FUNC_CLEAR_INTEG = 3'd3,
        FUNC_LOAD_INTEG  = 3'd4
    } t_func;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_P     = 3'd0;
    localparam logic [2:0] CFG_GAIN_I     = 3'd1;
    localparam logic [2:0] CFG_GAIN_D     = 3'd2;
    localparam logic [2:0] CFG_INTEG_LIM  = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_LIM = 3'd4;

    localparam int GAIN_W  = 16;
    localparam int DATA_W  = 32;
    localparam int LIMIT_W = 31;
    localparam int INTEG_W = 40;
    localparam int DERIV_W = 33;

    // operands of one update, handed from the front to the back
    typedef struct packed {
        logic signed [DATA_W-1:0]  err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } t_job;

endpackage

// ----- hdl/pid_controller_clamped.sv -----
// pid controller, q16.16 data with q8.8 gains, one item per cycle sustained while the queue has room
// path: an accepted item is written to the queue, then registered in the product
// stage, the sum stage and the clamp into the output register
// throughput: one update item per cycle while the queue has room, set by the integrator loop
// reset: synchronous active-low i_rst_n clears gains, limits, integrator,
// previous error, the queue and all valid flags
module pid_controller_clamped #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [2:0]                           i_cfg_index,
    input  logic [pidc_pkg::LIMIT_W-1:0]         i_cfg_data,
    // input items
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [2:0]                           i_func,
    input  logic signed [pidc_pkg::DATA_W-1:0]   i_error,
    input  logic signed [pidc_pkg::DATA_W-1:0]   i_rate,
    input  logic signed [pidc_pkg::DATA_W-1:0]   i_integral_value,
    // result items
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pidc_pkg::DATA_W-1:0]   o_drive,
    output logic                                 o_saturated
);

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic signed [pidc_pkg::GAIN_W-1:0] r_gain_p;
    logic signed [pidc_pkg::GAIN_W-1:0] r_gain_i;
    logic signed [pidc_pkg::GAIN_W-1:0] r_gain_d;
    logic [pidc_pkg::LIMIT_W-1:0]       r_integ_lim;
    logic [pidc_pkg::LIMIT_W-1:0]       r_output_lim;

    logic            front_push;
    logic            queue_full;
    pidc_pkg::t_job  front_job;
    pidc_pkg::t_job  queue_job;
    logic            queue_valid;
    logic            back_pop;

    // gains take the low 16 bits of the write data, limits all 31
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= '0;
            r_gain_i     <= '0;
            r_gain_d     <= '0;
            r_integ_lim  <= '0;
            r_output_lim <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pidc_pkg::CFG_GAIN_P:     r_gain_p     <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::CFG_GAIN_I:     r_gain_i     <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::CFG_GAIN_D:     r_gain_d     <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                pidc_pkg::CFG_INTEG_LIM:  r_integ_lim  <= i_cfg_data;
                pidc_pkg::CFG_OUTPUT_LIM: r_output_lim <= i_cfg_data;
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // front: accepts items while the queue is not full, keeps integrator and previous error,
    // and queues the operands of update items
    pidc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_error          (i_error),
        .i_rate           (i_rate),
        .i_integral_value (i_integral_value),
        .i_integral_limit (r_integ_lim),
        .i_full           (queue_full),
        .o_push           (front_push),
        .o_job            (front_job)
    );

    // short queue so the front keeps taking items while the output stalls
    pidc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_job   (queue_job)
    );

    // back: multiply, sum, scale, saturate and clamp
    pidc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_gain_p       (r_gain_p),
        .i_gain_i       (r_gain_i),
        .i_gain_d       (r_gain_d),
        .i_output_limit (r_output_lim),
        .i_job_valid    (queue_valid),
        .o_pop          (back_pop),
        .i_job          (queue_job),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_drive        (o_drive),
        .o_saturated    (o_saturated)
    );

endmodule

// ----- hdl/pidc_front.sv -----
module pidc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [2:0]                           i_func,
    input  logic signed [pidc_pkg::DATA_W-1:0]   i_error,
    input  logic signed [pidc_pkg::DATA_W-1:0]   i_rate,
    input  logic signed [pidc_pkg::DATA_W-1:0]   i_integral_value,
    input  logic [pidc_pkg::LIMIT_W-1:0]         i_integral_limit,
    input  logic                                 i_full,
    output logic                                 o_push,
    output pidc_pkg::t_job                       o_job
);

    logic signed [pidc_pkg::INTEG_W-1:0] r_integ, n_integ;
    logic signed [pidc_pkg::DATA_W-1:0]  r_last_err, n_last_err;

    logic                                accept;
    logic                                push;
    logic signed [pidc_pkg::INTEG_W:0]   integ_sum;
    logic signed [pidc_pkg::INTEG_W:0]   lim_pos;
    logic signed [pidc_pkg::INTEG_W:0]   lim_neg;
    logic signed [pidc_pkg::INTEG_W-1:0] integ_upd;
    logic signed [pidc_pkg::DERIV_W-1:0] deriv;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // integrator accumulate with clamp, one guard bit for overflow
    assign integ_sum = {r_integ[pidc_pkg::INTEG_W-1], r_integ}
                     + {{(pidc_pkg::INTEG_W+1-pidc_pkg::DATA_W){i_error[pidc_pkg::DATA_W-1]}},
                        i_error};
    assign lim_pos = {{(pidc_pkg::INTEG_W+1-pidc_pkg::LIMIT_W){1'b0}}, i_integral_limit};
    assign lim_neg = -lim_pos;

    always_comb begin
        if (i_integral_limit != '0) begin
            if (integ_sum > lim_pos) begin
                integ_upd = lim_pos[pidc_pkg::INTEG_W-1:0];
            end else if (integ_sum < lim_neg) begin
                integ_upd = lim_neg[pidc_pkg::INTEG_W-1:0];
            end else begin
                integ_upd = integ_sum[pidc_pkg::INTEG_W-1:0];
            end
        end else begin
            // saturate at the 40-bit range
            if (integ_sum[pidc_pkg::INTEG_W] != integ_sum[pidc_pkg::INTEG_W-1]) begin
                integ_upd = {integ_sum[pidc_pkg::INTEG_W],
                             {(pidc_pkg::INTEG_W-1){~integ_sum[pidc_pkg::INTEG_W]}}};
            end else begin
                integ_upd = integ_sum[pidc_pkg::INTEG_W-1:0];
            end
        end
    end

    always_comb begin
        if (i_func == pidc_pkg::FUNC_UPDATE_DIFF) begin
            deriv = {i_error[pidc_pkg::DATA_W-1], i_error}
                  - {r_last_err[pidc_pkg::DATA_W-1], r_last_err};
        end else begin
            deriv = {i_rate[pidc_pkg::DATA_W-1], i_rate};
        end
    end

    always_comb begin
        n_integ    = r_integ;
        n_last_err = r_last_err;
        push       = 1'b0;
        if (accept) begin
            case (i_func)
                pidc_pkg::FUNC_UPDATE_DIFF,
                pidc_pkg::FUNC_UPDATE_RATE: begin
                    n_integ    = integ_upd;
                    n_last_err = i_error;
                    push       = 1'b1;
                end
                pidc_pkg::FUNC_RESET: begin
                    n_integ    = '0;
                    n_last_err = '0;
                end
                pidc_pkg::FUNC_CLEAR_INTEG: begin
                    n_integ = '0;
                end
                pidc_pkg::FUNC_LOAD_INTEG: begin
                    n_integ = {{(pidc_pkg::INTEG_W-pidc_pkg::DATA_W)
                                {i_integral_value[pidc_pkg::DATA_W-1]}}, i_integral_value};
                end
                default: begin
                    // unused codes leave state alone
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else begin
            r_integ    <= n_integ;
            r_last_err <= n_last_err;
        end
    end

    assign o_push      = push;
    assign o_job.err   = i_error;
    assign o_job.integ = integ_upd;
    assign o_job.deriv = deriv;

endmodule

// ----- hdl/pidc_queue.sv -----
module pidc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pidc_pkg::t_job  i_job,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output pidc_pkg::t_job  o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    pidc_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign do_push = i_push && (r_count != FULL);
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

endmodule

// ----- hdl/pidc_back.sv -----
module pidc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [pidc_pkg::GAIN_W-1:0]   i_gain_p,
    input  logic signed [pidc_pkg::GAIN_W-1:0]   i_gain_i,
    input  logic signed [pidc_pkg::GAIN_W-1:0]   i_gain_d,
    input  logic [pidc_pkg::LIMIT_W-1:0]         i_output_limit,
    input  logic                                 i_job_valid,
    output logic                                 o_pop,
    input  pidc_pkg::t_job                       i_job,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pidc_pkg::DATA_W-1:0]   o_drive,
    output logic                                 o_saturated
);

    localparam int PP_W  = pidc_pkg::GAIN_W + pidc_pkg::DATA_W;
    localparam int PI_W  = pidc_pkg::GAIN_W + pidc_pkg::INTEG_W;
    localparam int PD_W  = pidc_pkg::GAIN_W + pidc_pkg::DERIV_W;
    localparam int SUM_W = PI_W + 2;
    localparam int Y_W   = SUM_W - 8;
    localparam int LIM_W = pidc_pkg::DATA_W + 1;

    // stage 1: products
    logic                    r_s1_valid;
    logic signed [PP_W-1:0]  r_prod_p;
    logic signed [PI_W-1:0]  r_prod_i;
    logic signed [PD_W-1:0]  r_prod_d;
    // stage 2: exact sum
    logic                    r_s2_valid;
    logic signed [SUM_W-1:0] r_sum;
    // output register
    logic                              r_out_valid;
    logic signed [pidc_pkg::DATA_W-1:0] r_drive, n_drive;
    logic                              r_sat, n_sat;

    logic out_go, s2_go, s1_go;
    logic signed [PP_W-1:0]  prod_p;
    logic signed [PI_W-1:0]  prod_i;
    logic signed [PD_W-1:0]  prod_d;
    logic signed [SUM_W-1:0] sum;
    logic signed [Y_W-1:0]   y;
    logic signed [pidc_pkg::DATA_W-1:0] y32;
    logic signed [LIM_W-1:0] y_ext, lim_pos, lim_neg;

    assign out_go = !r_out_valid || i_ready;
    assign s2_go  = !r_s2_valid || out_go;
    assign s1_go  = !r_s1_valid || s2_go;
    assign o_pop  = i_job_valid && s1_go;

    assign prod_p = i_gain_p * i_job.err;
    assign prod_i = i_gain_i * i_job.integ;
    assign prod_d = i_gain_d * i_job.deriv;

    assign sum = {{(SUM_W-PP_W){r_prod_p[PP_W-1]}}, r_prod_p}
               + {{(SUM_W-PI_W){r_prod_i[PI_W-1]}}, r_prod_i}
               + {{(SUM_W-PD_W){r_prod_d[PD_W-1]}}, r_prod_d};

    // floor divide by 256, then saturate and clamp
    assign y       = r_sum[SUM_W-1:8];
    assign lim_pos = {2'b00, i_output_limit};
    assign lim_neg = -lim_pos;
    assign y_ext   = {y32[pidc_pkg::DATA_W-1], y32};

    always_comb begin
        n_sat = 1'b0;
        if (!y[Y_W-1] && (|y[Y_W-2:pidc_pkg::DATA_W-1])) begin
            y32   = {1'b0, {(pidc_pkg::DATA_W-1){1'b1}}};
            n_sat = 1'b1;
        end else if (y[Y_W-1] && !(&y[Y_W-2:pidc_pkg::DATA_W-1])) begin
            y32   = {1'b1, {(pidc_pkg::DATA_W-1){1'b0}}};
            n_sat = 1'b1;
        end else begin
            y32 = y[pidc_pkg::DATA_W-1:0];
        end
        n_drive = y32;
        if (i_output_limit != '0) begin
            if (y_ext > lim_pos) begin
                n_drive = lim_pos[pidc_pkg::DATA_W-1:0];
                n_sat   = 1'b1;
            end else if (y_ext < lim_neg) begin
                n_drive = lim_neg[pidc_pkg::DATA_W-1:0];
                n_sat   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_s1_valid <= i_job_valid;
            end
            if (s2_go) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_go) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod_p <= prod_p;
            r_prod_i <= prod_i;
            r_prod_d <= prod_d;
        end
        if (s2_go && r_s1_valid) begin
            r_sum <= sum;
        end
        if (out_go && r_s2_valid) begin
            r_drive <= n_drive;
            r_sat   <= n_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_drive     = r_drive;
    assign o_saturated = r_sat;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    // clock and run control
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    // pipeline is three deep; items with no result may still be in flight
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_OFF_LEN   = 60;

    // func codes the block must ignore
    localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
    localparam logic [2:0] FUNC_SPARE_MID = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

    // saturation bounds of the integrator and of the 32-bit drive
    localparam longint INTEG_HI = (64'sd1 <<< 39) - 64'sd1;
    localparam longint INTEG_LO = -(64'sd1 <<< 39);
    localparam longint DRIVE_HI = (64'sd1 <<< 31) - 64'sd1;
    localparam longint DRIVE_LO = -(64'sd1 <<< 31);

    typedef struct {
        logic signed [pidc_pkg::DATA_W-1:0] drive;
        logic                               saturated;
    } t_drive_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [2:0]                           i_cfg_index;
    logic [pidc_pkg::LIMIT_W-1:0]         i_cfg_data;
    logic                                 i_valid;
    logic                                 o_ready;
    logic [2:0]                           i_func;
    logic signed [pidc_pkg::DATA_W-1:0]   i_error;
    logic signed [pidc_pkg::DATA_W-1:0]   i_rate;
    logic signed [pidc_pkg::DATA_W-1:0]   i_integral_value;
    logic                                 o_valid;
    logic                                 i_ready;
    logic signed [pidc_pkg::DATA_W-1:0]   o_drive;
    logic                                 o_saturated;

    // predictor copy of the block's registers and state
    longint gain_p_q;
    longint gain_i_q;
    longint gain_d_q;
    longint integ_lim_q;
    longint out_lim_q;
    longint integ_acc;
    longint prev_err;

    // drive values still owed by the block, oldest first
    t_drive_result drive_q[$];
    t_drive_result owed;

    int  mismatches   = 0;
    int  stall_cycles = 0;
    int  rx_hold      = 0;
    bit  tx_idle_en   = 1'b1;
    bit  rx_idle_en   = 1'b1;

    pid_controller_clamped i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_error          (i_error),
        .i_rate           (i_rate),
        .i_integral_value (i_integral_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_drive          (o_drive),
        .o_saturated      (o_saturated)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predictor: apply one accepted item, queue the drive it causes
    // ---------------------------------------------------------------
    function automatic void predict_drive(input logic [2:0] fn,
                                          input logic signed [pidc_pkg::DATA_W-1:0] err,
                                          input logic signed [pidc_pkg::DATA_W-1:0] rate,
                                          input logic signed [pidc_pkg::DATA_W-1:0] ival);
        longint        e;
        longint        d;
        longint        acc;
        t_drive_result r;
        e = err;
        case (fn)
            pidc_pkg::FUNC_RESET: begin
                integ_acc = 0;
                prev_err  = 0;
            end
            pidc_pkg::FUNC_CLEAR_INTEG: integ_acc = 0;
            // loaded value is not clamped until the next update
            pidc_pkg::FUNC_LOAD_INTEG:  integ_acc = ival;
            pidc_pkg::FUNC_UPDATE_DIFF, pidc_pkg::FUNC_UPDATE_RATE: begin
                integ_acc = integ_acc + e;
                // limit register clamps, zero falls back to 40-bit saturation
                if (integ_lim_q != 0) begin
                    if (integ_acc > integ_lim_q)
                        integ_acc = integ_lim_q;
                    else if (integ_acc < -integ_lim_q)
                        integ_acc = -integ_lim_q;
                end else begin
                    if (integ_acc > INTEG_HI)
                        integ_acc = INTEG_HI;
                    else if (integ_acc < INTEG_LO)
                        integ_acc = INTEG_LO;
                end
                if (fn == pidc_pkg::FUNC_UPDATE_DIFF)
                    d = e - prev_err;
                else
                    d = longint'(rate);
                // q24.24 sum back to q16.16, floor rounding
                acc = (gain_p_q * e + gain_i_q * integ_acc + gain_d_q * d) >>> 8;
                r.saturated = 1'b0;
                if (acc > DRIVE_HI) begin
                    acc = DRIVE_HI;
                    r.saturated = 1'b1;
                end else if (acc < DRIVE_LO) begin
                    acc = DRIVE_LO;
                    r.saturated = 1'b1;
                end
                // a drive equal to the limit passes untouched
                if (out_lim_q != 0) begin
                    if (acc > out_lim_q) begin
                        acc = out_lim_q;
                        r.saturated = 1'b1;
                    end else if (acc < -out_lim_q) begin
                        acc = -out_lim_q;
                        r.saturated = 1'b1;
                    end
                end
                r.drive  = acc[pidc_pkg::DATA_W-1:0];
                prev_err = e;
                drive_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // random field values
    // ---------------------------------------------------------------
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       pick_word = 32'h7fff_ffff;
            1:       pick_word = 32'h8000_0000;
            2, 3, 4: pick_word = $urandom_range(0, 32'h7_ffff) - 32'h4_0000;
            default: pick_word = $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0:          pick_gain = 16'h8000;
            1:          pick_gain = 16'h7fff;
            2:          pick_gain = 16'h0000;
            3:          pick_gain = 16'h0100;
            4, 5, 6:    pick_gain = 16'($urandom_range(0, 2047) - 1024);
            default:    pick_gain = 16'($urandom);
        endcase
    endfunction

    function automatic logic [pidc_pkg::LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_limit = '0;
            4:          pick_limit = {pidc_pkg::LIMIT_W{1'b1}};
            5, 6:       pick_limit = pidc_pkg::LIMIT_W'($urandom_range(1, 32'h7_ffff));
            default:    pick_limit = pidc_pkg::LIMIT_W'($urandom);
        endcase
    endfunction

    // mostly updates so the integrator builds up, the rest state changes and noise
    function automatic logic [2:0] pick_func();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            pick_func = pidc_pkg::FUNC_UPDATE_DIFF;
        else if (roll < 80)
            pick_func = pidc_pkg::FUNC_UPDATE_RATE;
        else if (roll < 86)
            pick_func = pidc_pkg::FUNC_LOAD_INTEG;
        else if (roll < 90)
            pick_func = pidc_pkg::FUNC_CLEAR_INTEG;
        else if (roll < 93)
            pick_func = pidc_pkg::FUNC_RESET;
        else
            pick_func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    endfunction

    // ---------------------------------------------------------------
    // shared tasks
    // ---------------------------------------------------------------

    // offer one item, hold it until accepted, then predict it
    task automatic send_item(input logic [2:0] fn, input logic [31:0] err,
                             input logic [31:0] rate, input logic [31:0] ival);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_func           <= fn;
        i_error          <= err;
        i_rate           <= rate;
        i_integral_value <= ival;
        do @(posedge i_clk); while (!o_ready);
        predict_drive(fn, err, rate, ival);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(pick_func(), pick_word(), pick_word(), pick_word());
    endtask

    // stop offering and let every owed drive and in-flight item drain
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all five registers back to back, only while idle
    task automatic load_settings(input logic [15:0] gp, input logic [15:0] gi,
                                 input logic [15:0] gd,
                                 input logic [pidc_pkg::LIMIT_W-1:0] ilim,
                                 input logic [pidc_pkg::LIMIT_W-1:0] olim);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pidc_pkg::CFG_GAIN_P;
        i_cfg_data  <= {{(pidc_pkg::LIMIT_W-16){gp[15]}}, gp};
        @(posedge i_clk);
        i_cfg_index <= pidc_pkg::CFG_GAIN_I;
        i_cfg_data  <= {{(pidc_pkg::LIMIT_W-16){gi[15]}}, gi};
        @(posedge i_clk);
        i_cfg_index <= pidc_pkg::CFG_GAIN_D;
        i_cfg_data  <= {{(pidc_pkg::LIMIT_W-16){gd[15]}}, gd};
        @(posedge i_clk);
        i_cfg_index <= pidc_pkg::CFG_INTEG_LIM;
        i_cfg_data  <= ilim;
        @(posedge i_clk);
        i_cfg_index <= pidc_pkg::CFG_OUTPUT_LIM;
        i_cfg_data  <= olim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gain_p_q    = longint'($signed(gp));
        gain_i_q    = longint'($signed(gi));
        gain_d_q    = longint'($signed(gd));
        integ_lim_q = longint'(ilim);
        out_lim_q   = longint'(olim);
    endtask

    // ---------------------------------------------------------------
    // test tasks
    // ---------------------------------------------------------------

    // registers at reset are zero, so every update must give zero drive
    task automatic test_after_reset();
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_RATE, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, pick_word(), pick_word(), pick_word());
        wait_drained();
    endtask

    // extremes of every field, every func, spare codes, clamp boundaries
    task automatic test_directed_corners();
        // full-scale gains: 32-bit saturation from both sides
        load_settings(16'h7fff, 16'h8000, 16'h7fff, '0, '0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'h7fff_ffff, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'h8000_0000, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_RATE, 32'h0, 32'h8000_0000, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_RATE, 32'h0, 32'h7fff_ffff, 32'h0);
        send_item(pidc_pkg::FUNC_LOAD_INTEG, 32'h0, 32'h0, 32'h7fff_ffff);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'h0, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_LOAD_INTEG, 32'h0, 32'h0, 32'h8000_0000);
        send_item(pidc_pkg::FUNC_UPDATE_RATE, 32'h0, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_CLEAR_INTEG, 32'h0, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'h8000_0000, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_RESET, 32'h0, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'h0000_0100, 32'h0, 32'h0);
        // spare codes must leave state alone and give nothing
        send_item(FUNC_SPARE_LO, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(FUNC_SPARE_MID, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(FUNC_SPARE_HI, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'h0000_0100, 32'h0, 32'h0);
        wait_drained();

        // unity proportional gain: drive on and just past the output limit
        load_settings(16'h0100, 16'h0000, 16'h0000, '0, 31'd5000);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'd5000, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'd5001, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, -32'sd5000, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, -32'sd5001, 32'h0, 32'h0);
        wait_drained();

        // unity integral gain: integrator on and past its limit
        load_settings(16'h0000, 16'h0100, 16'h0000, 31'd1000, '0);
        send_item(pidc_pkg::FUNC_LOAD_INTEG, 32'h0, 32'h0, 32'd900);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'd100, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_DIFF, 32'd1, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_RATE, -32'sd2001, 32'h0, 32'h0);
        send_item(pidc_pkg::FUNC_UPDATE_RATE, -32'sd1, 32'h0, 32'h0);
        wait_drained();
    endtask

    // no integrator limit: run into the 40-bit rails both ways
    task automatic test_integrator_saturation();
        load_settings(16'h0000, 16'h0001, 16'h0000, '0, '0);
        repeat (262) send_item(pidc_pkg::FUNC_UPDATE_DIFF,
                               32'h7fff_ffff - $urandom_range(0, 32'hf_ffff),
                               pick_word(), pick_word());
        send_item(pidc_pkg::FUNC_RESET, pick_word(), pick_word(), pick_word());
        repeat (262) send_item(pidc_pkg::FUNC_UPDATE_RATE,
                               32'h8000_0000 + $urandom_range(0, 32'hf_ffff),
                               pick_word(), pick_word());
        wait_drained();
    endtask

    // several register settings, the first one at the extremes
    task automatic test_random_phases();
        load_settings(16'h8000, 16'h7fff, 16'h8000, {pidc_pkg::LIMIT_W{1'b1}},
                      {pidc_pkg::LIMIT_W{1'b1}});
        send_random(40);
        wait_drained();
        repeat (3) begin
            load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
            send_random(40);
            wait_drained();
        end
    endtask

    // receiver holds off while items keep coming, the block must stall its input
    task automatic test_backpressure();
        load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
        rx_hold = HOLD_OFF_LEN;
        repeat (30) send_item(pidc_pkg::FUNC_UPDATE_DIFF, pick_word(), pick_word(),
                              pick_word());
        wait_drained();
    endtask

    // closing stretch at full rate on both sides
    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
        send_random(60);
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // receiver: random stall bursts, plus the long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
                i_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // checker: each accepted result against the oldest owed drive
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: drive %h saturated %b",
                             o_drive, o_saturated);
            end else begin
                owed = drive_q.pop_front();
                if (o_drive !== owed.drive || o_saturated !== owed.saturated) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("drive mismatch: expected %h/%b actual %h/%b",
                                 owed.drive, owed.saturated, o_drive, o_saturated);
                end
            end
        end
    end

    // watchdog: too long with no handshake on any port
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = pidc_pkg::CFG_GAIN_P;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_func           = pidc_pkg::FUNC_UPDATE_DIFF;
        i_error          = '0;
        i_rate           = '0;
        i_integral_value = '0;
        i_ready          = 1'b0;
        gain_p_q         = 0;
        gain_i_q         = 0;
        gain_d_q         = 0;
        integ_lim_q      = 0;
        out_lim_q        = 0;
        integ_acc        = 0;
        prev_err         = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_directed_corners();
        test_integrator_saturation();
        test_random_phases();
        test_backpressure();
        test_steady_stream();

        if (mismatches == 0 && drive_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
